[rtl/hmcr_pkg.sv]
package hmcr_pkg;

    localparam int DEF_COUNT_BITS = 16;
    localparam int PEAK_W         = 16;
    localparam int SCALED_W       = 19;     // 6 * peak fits here
    localparam int NUM_SEG        = 6;
    localparam int K_W            = 3;
    localparam int CHAN_W         = 8;
    localparam int QUO_W          = CHAN_W;
    localparam int NUM_W          = PEAK_W + CHAN_W;   // 255 * d
    localparam int NUM_CHAN       = 3;
    localparam int FULL_CHAN      = 255;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_PEAK = 2'd0;
    localparam logic [PEAK_W-1:0]     PEAK_RESET = 16'd1;

    // How one channel moves across a segment, bottom color to top color.
    typedef enum logic [1:0] {
        RAMP_ZERO,      // 0 at both ends
        RAMP_FULL,      // 255 at both ends
        RAMP_RISE,      // 0 -> 255
        RAMP_FALL       // 255 -> 0
    } t_ramp;

    // Sideband that rides along the divider stages.
    typedef struct packed {
        logic           in_range;
        logic [K_W-1:0] seg;
    } t_side;

    // [segment][red, green, blue]
    localparam t_ramp RAMP_TABLE [0:2**K_W-1][0:NUM_CHAN-1] = '{
        '{RAMP_ZERO, RAMP_ZERO, RAMP_RISE},   // black -> blue
        '{RAMP_ZERO, RAMP_RISE, RAMP_FULL},   // blue -> cyan
        '{RAMP_ZERO, RAMP_FULL, RAMP_RISE},   // green -> cyan
        '{RAMP_FALL, RAMP_FULL, RAMP_ZERO},   // yellow -> green
        '{RAMP_FULL, RAMP_RISE, RAMP_ZERO},   // red -> yellow
        '{RAMP_FULL, RAMP_FALL, RAMP_FALL},   // white -> red
        '{RAMP_ZERO, RAMP_ZERO, RAMP_ZERO},
        '{RAMP_ZERO, RAMP_ZERO, RAMP_ZERO}
    };

    function automatic logic [CHAN_W-1:0] chan_pick(
        input t_ramp             kind,
        input logic [CHAN_W-1:0] up,
        input logic [CHAN_W-1:0] down
    );
        logic [CHAN_W-1:0] v;
        unique case (kind)
            RAMP_ZERO: v = '0;
            RAMP_FULL: v = CHAN_W'(FULL_CHAN);
            RAMP_RISE: v = up;
            RAMP_FALL: v = down;
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/heat_map_color_ramp.sv]
// Channel    | Dir | Handshake                    | Contents
// s (count)  | in  | i_s_tvalid / o_s_tready      | tdata: count
// m (color)  | out | o_m_tvalid / i_m_tready      | tdata: red, green, blue, alpha; tuser: in_range
// apb (cfg)  | in  | psel, penable, pwrite, pready| reg 0 at 0x0: peak_count
//
// One count per clock while the output is not stalled; stages: range check and 6 * count,
// segment select, scale by 255, eight one-bit divider stages (255*d / peak), output register.
// Synchronous active-low reset clears all valid bits; peak_count resets to 1.
// A stall on the output only holds stages that are full; empty stages keep
// filling, so bubbles are squeezed out before the input is held off.
module heat_map_color_ramp #(
    parameter  int COUNT_BITS = hmcr_pkg::DEF_COUNT_BITS,
    localparam int TDATA_IN_W = ((COUNT_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [TDATA_IN_W-1:0]             i_s_tdata,   // [COUNT_BITS-1:0] count
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [31:0]                       o_m_tdata,   // red, green, blue, alpha
    output logic                              o_m_tuser,   // in_range
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hmcr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hmcr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hmcr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import hmcr_pkg::*;

    localparam int CW   = (COUNT_BITS > PEAK_W) ? COUNT_BITS : PEAK_W;
    localparam int NSTG = 3 + QUO_W + 1;

    // config register
    logic [PEAK_W-1:0] r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= PEAK_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_PEAK)) begin
            r_peak <= pwdata[PEAK_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PEAK) ? APB_DATA_W'(r_peak) : '0;

    // stage valids and per-stage load enables
    logic [NSTG-1:0] w_v;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !w_v[NSTG-1] || i_m_tready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            w_en[i] = !w_v[i] || w_en[i+1];
        end
    end

    assign o_s_tready = w_en[0];

    // stage 1: range check, 6 * count
    logic [CW-1:0]       w_c;
    logic                w_in_range;
    logic [SCALED_W-1:0] w_c16;
    logic                r_s1_v;
    logic                r_s1_in;
    logic [SCALED_W-1:0] r_s1_scaled;

    always_comb begin
        w_c        = CW'(i_s_tdata[COUNT_BITS-1:0]);
        w_in_range = (w_c != '0) && (w_c <= CW'(r_peak));
        w_c16      = SCALED_W'(w_c[PEAK_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en[0]) begin
            r_s1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_in     <= w_in_range;
            r_s1_scaled <= (w_c16 << 2) + (w_c16 << 1);
        end
    end

    // stage 2: segment and offset d = 6c - k*peak
    logic [SCALED_W-1:0] w_mul [0:2**K_W-1];
    logic [K_W-1:0]      w_k;
    logic [SCALED_W-1:0] w_d;
    logic                r_s2_v;
    t_side               r_s2_side;
    logic [PEAK_W-1:0]   r_s2_d;

    always_comb begin
        for (int j = 0; j < 2**K_W; j++) begin
            w_mul[j] = (j < NUM_SEG) ? SCALED_W'(r_peak) * SCALED_W'(j) : '0;
        end
        w_k = '0;
        for (int j = 1; j < NUM_SEG; j++) begin
            if (r_s1_scaled > w_mul[j]) begin
                w_k = K_W'(j);
            end
        end
        w_d = r_s1_scaled - w_mul[w_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en[1]) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_side.in_range <= r_s1_in;
            r_s2_side.seg      <= w_k;
            r_s2_d             <= w_d[PEAK_W-1:0];
        end
    end

    // stage 3: numerator 255 * d
    logic             r_s3_v;
    t_side            r_s3_side;
    logic [NUM_W-1:0] r_s3_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_en[2]) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_side <= r_s2_side;
            r_s3_num  <= {r_s2_d, CHAN_W'(0)} - NUM_W'(r_s2_d);
        end
    end

    // divider: one quotient bit per stage, MSB first
    logic [QUO_W:0]   w_dv;
    logic [NUM_W-1:0] w_drem  [0:QUO_W];
    logic [QUO_W-1:0] w_dquo  [0:QUO_W];
    t_side            w_dside [0:QUO_W];

    assign w_dv[0]    = r_s3_v;
    assign w_drem[0]  = r_s3_num;
    assign w_dquo[0]  = '0;
    assign w_dside[0] = r_s3_side;

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        hmcr_div_stage #(
            .BIT (QUO_W - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en[3+g]),
            .i_valid (w_dv[g]),
            .i_rem   (w_drem[g]),
            .i_quo   (w_dquo[g]),
            .i_side  (w_dside[g]),
            .i_peak  (r_peak),
            .o_valid (w_dv[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_quo   (w_dquo[g+1]),
            .o_side  (w_dside[g+1])
        );
    end

    // output stage
    logic [CHAN_W:0]   w_ceil;
    logic [CHAN_W-1:0] w_up;
    logic [CHAN_W-1:0] w_down;
    logic [31:0]       n_out_data;
    t_side             w_fs;
    logic              r_out_v;
    logic [31:0]       r_out_data;
    logic              r_out_user;

    always_comb begin
        w_fs   = w_dside[QUO_W];
        w_up   = w_dquo[QUO_W];
        // falling ramp: 255 - ceil(255*d/peak)
        w_ceil = (CHAN_W+1)'(w_up) + (CHAN_W+1)'(w_drem[QUO_W] != '0);
        w_down = CHAN_W'((CHAN_W+1)'(FULL_CHAN) - w_ceil);
        n_out_data = '0;
        if (w_fs.in_range) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                n_out_data[ch*CHAN_W +: CHAN_W] =
                    chan_pick(RAMP_TABLE[w_fs.seg][ch], w_up, w_down);
            end
            n_out_data[NUM_CHAN*CHAN_W +: CHAN_W] = CHAN_W'(FULL_CHAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en[NSTG-1]) begin
            r_out_v <= w_dv[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_out_data <= n_out_data;
            r_out_user <= w_fs.in_range;
        end
    end

    assign w_v[0]            = r_s1_v;
    assign w_v[1]            = r_s2_v;
    assign w_v[2]            = r_s3_v;
    assign w_v[3 +: QUO_W]   = w_dv[QUO_W:1];
    assign w_v[NSTG-1]       = r_out_v;

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

[rtl/hmcr_div_stage.sv]
module hmcr_div_stage #(
    parameter int BIT = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [hmcr_pkg::NUM_W-1:0]   i_rem,
    input  logic [hmcr_pkg::QUO_W-1:0]   i_quo,
    input  hmcr_pkg::t_side              i_side,
    input  logic [hmcr_pkg::PEAK_W-1:0]  i_peak,
    output logic                         o_valid,
    output logic [hmcr_pkg::NUM_W-1:0]   o_rem,
    output logic [hmcr_pkg::QUO_W-1:0]   o_quo,
    output hmcr_pkg::t_side              o_side
);
    import hmcr_pkg::*;

    logic [NUM_W-1:0] w_sub;
    logic             w_ge;
    logic [NUM_W-1:0] n_rem;
    logic [QUO_W-1:0] n_quo;

    logic             r_valid;
    logic [NUM_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    t_side            r_side;

    // one restoring step: try peak << BIT
    always_comb begin
        w_sub = NUM_W'(i_peak) << BIT;
        w_ge  = (i_rem >= w_sub);
        n_rem = w_ge ? (i_rem - w_sub) : i_rem;
        n_quo = i_quo;
        n_quo[BIT] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_side  = r_side;

endmodule
